// File: rtl/kerl_pkg.sv
// Shared types and constants of the keyed event rate limiter.
// Holds the walking token, the claim broadcast, the controller states and codes.
// No dependencies.
`default_nettype none

package kerl_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int CSR_ADDR_W    = 3;

   localparam logic [31:0] INTERVAL_RESET = 32'd3600000;

   localparam logic       REG_MIN_INTERVAL = 1'b0;

   localparam logic       KIND_CHECK = 1'b0;
   localparam logic       KIND_MARK  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO_KEY = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_HOLD
   } kerl_state_type;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic        zero;
      logic [31:0] key;
      logic [31:0] now;
      logic        hit;
      logic        elig;
      logic        free_found;
   } kerl_token_type;

   typedef struct packed {
      logic        claim;
      logic [31:0] key;
      logic [31:0] now;
   } kerl_claim_type;

endpackage

`default_nettype wire

// File: rtl/kerl_cell.sv
// One table entry of the rate limiter: valid mark, key and last queued time.
// Looks at the token passing by and hands it on, registered, in the next cycle. Uses kerl_pkg.
`default_nettype none

module kerl_cell
   import kerl_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [31:0]    interval,
   input  wire kerl_token_type tok_in,
   output kerl_token_type      tok_out,
   input  wire kerl_claim_type claim
);

   logic           valid_ff, valid_in;
   logic [31:0]    key_ff, key_in;
   logic [31:0]    time_ff, time_in;
   logic           cand_ff, cand_in;
   kerl_token_type tok_ff, tok_in_next;
   logic           active;
   logic           hit_here;
   logic           free_here;
   logic [31:0]    age;

   assign active    = tok_in.valid && !tok_in.zero;
   assign hit_here  = active && valid_ff && (key_ff == tok_in.key) && !tok_in.hit;
   assign free_here = active && !valid_ff && !tok_in.free_found;
   assign age       = tok_in.now - time_ff;

   always_comb begin
      tok_in_next            = tok_in;
      tok_in_next.hit        = tok_in.hit | hit_here;
      tok_in_next.elig       = tok_in.elig |
                               (hit_here && (tok_in.kind == KIND_CHECK) && (age >= interval));
      tok_in_next.free_found = tok_in.free_found | free_here;
   end

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      time_in  = time_ff;
      cand_in  = cand_ff;
      if (tok_in.valid) begin
         cand_in = free_here;
      end
      if (hit_here && (tok_in.kind == KIND_MARK)) begin
         time_in = tok_in.now;
      end
      if (claim.claim && cand_ff) begin
         valid_in = 1'b1;
         key_in   = claim.key;
         time_in  = claim.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cand_ff  <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cand_ff  <= cand_in;
         tok_ff   <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      time_ff <= time_in;
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

// File: rtl/keyed_event_rate_limiter.sv
// Keyed event rate limiter: an accepted beat walks a row of SLOTS entry cells, one cell
// per cycle; its result is then loaded into the output register, or into a hold register
// while the output register holds a result not yet taken. The next beat is accepted once
// that result is in the output register, even while it waits to be taken, so only one
// beat is in flight at a time. A mark claims the lowest free entry when the walk ends.
// Uses kerl_pkg and kerl_cell.
`default_nettype none

module keyed_event_rate_limiter
   import kerl_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_kind,
   input  wire logic [31:0]           req_signature,
   input  wire logic [31:0]           req_now_ms,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_eligible,
   output logic [1:0]                 rsp_status,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   kerl_state_type state_ff, state_in;
   logic [31:0]    interval_ff;
   kerl_token_type tok [SLOTS+1];
   kerl_claim_type claim;
   logic           accept;
   logic           can_load;
   logic           load_fresh, load_held, save_held;
   logic           res_elig;
   logic [1:0]     res_status;
   logic           held_elig_ff;
   logic [1:0]     held_status_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_elig_ff;
   logic [1:0]     rsp_status_ff;
   logic           reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[2];
   assign prdata    = (reg_index == REG_MIN_INTERVAL) ? interval_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else if (psel && penable && pwrite && (reg_index == REG_MIN_INTERVAL)) begin
         interval_ff <= pwdata;
      end
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      tok[0]            = '0;
      tok[0].valid      = accept;
      tok[0].kind       = req_kind;
      tok[0].zero       = (req_signature == 32'd0);
      tok[0].key        = req_signature;
      tok[0].now        = req_now_ms;
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      kerl_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .interval (interval_ff),
         .tok_in   (tok[i]),
         .tok_out  (tok[i+1]),
         .claim    (claim)
      );
   end

   always_comb begin
      res_elig   = 1'b0;
      res_status = STATUS_OK;
      if (tok[SLOTS].zero) begin
         res_status = STATUS_ZERO_KEY;
      end else if (tok[SLOTS].kind == KIND_CHECK) begin
         res_elig = tok[SLOTS].hit ? tok[SLOTS].elig : tok[SLOTS].free_found;
      end else if (!tok[SLOTS].hit && !tok[SLOTS].free_found) begin
         res_status = STATUS_FULL;
      end
   end

   assign can_load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_WALK;
         end
         S_WALK: begin
            if (tok[SLOTS].valid) state_in = can_load ? S_IDLE : S_HOLD;
         end
         S_HOLD: begin
            if (can_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      load_fresh = 1'b0;
      load_held  = 1'b0;
      save_held  = 1'b0;
      unique case (state_ff)
         S_IDLE: req_ready = !reset;
         S_WALK: begin
            load_fresh = tok[SLOTS].valid && can_load;
            save_held  = tok[SLOTS].valid && !can_load;
         end
         S_HOLD: load_held = can_load;
         default: req_ready = 1'b0;
      endcase
   end

   always_comb begin
      claim.claim = tok[SLOTS].valid && !tok[SLOTS].zero && (tok[SLOTS].kind == KIND_MARK) &&
                    !tok[SLOTS].hit && tok[SLOTS].free_found;
      claim.key   = tok[SLOTS].key;
      claim.now   = tok[SLOTS].now;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_fresh || load_held) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (save_held) begin
         held_elig_ff   <= res_elig;
         held_status_ff <= res_status;
      end
      if (load_fresh) begin
         rsp_elig_ff   <= res_elig;
         rsp_status_ff <= res_status;
      end else if (load_held) begin
         rsp_elig_ff   <= held_elig_ff;
         rsp_status_ff <= held_status_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_eligible = rsp_elig_ff;
   assign rsp_status   = rsp_status_ff;

`ifndef SYNTHESIS
   a_accept_walks: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_WALK))
      else $error("accepted beat did not start a walk");

   a_exit_in_walk: assert property (@(posedge clock) disable iff (reset)
      tok[SLOTS].valid |-> (state_ff == S_WALK))
      else $error("token left the cell row outside a walk");

   a_eligible_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_eligible) |-> (rsp_status == STATUS_OK))
      else $error("eligible result with a non-ok status");

   a_claim_mark: assert property (@(posedge clock) disable iff (reset)
      claim.claim |-> (tok[SLOTS].kind == KIND_MARK) && load_fresh || claim.claim && save_held)
      else $error("entry claimed without a finishing mark");
`endif

endmodule

`default_nettype wire
